// ----- rtl/core/hwvc_pkg.sv -----
package hwvc_pkg;

  // Request type codes.
  localparam logic [1:0] REQ_COUNT  = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // Hash constants.
  localparam logic [31:0] HASH_MUL = 32'd237;

  // Hash of the end-of-sentence word "</s>" before reduction to a slot.
  localparam logic [31:0] SENT_HASH = 32'd801390440;
  localparam int unsigned SENT_LEN  = 4;

  // Result field widths.
  localparam int unsigned OUT_W = 13;
  localparam int unsigned CNT_W = 32;

  // What kind of result the response carries.
  typedef enum logic [1:0] {
    RK_CLEAR  = 2'd0,
    RK_ABSENT = 2'd1,
    RK_FOUND  = 2'd2,
    RK_NEW    = 2'd3
  } resp_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take;
    logic       clr_init;
    logic       clr_step;
    logic       mod_init;
    logic       mod_step;
    logic       from_slot;
    logic       scan_init;
    logic       cand_next;
    logic       cmp_init;
    logic       k_next;
    logic       slot_wr;
    logic       cnt_upd;
    logic       append;
    logic       copy_wr;
    logic       resp_load;
    resp_kind_t kind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic slot_hit;
    logic slot_valid;
    logic len_eq;
    logic len_zero;
    logic byte_eq;
    logic k_last;
    logic scan;
    logic scan_end;
    logic req_cnt;
    logic full_now;
    logic out_free;
  } sts_t;

  // Characters of the end-of-sentence word.
  function automatic logic [7:0] endw_byte(input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0: b = 8'h3C;
      2'd1: b = 8'h2F;
      2'd2: b = 8'h73;
      default: b = 8'h3E;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/hashed_word_vocabulary_counter.sv -----
// Hashed word vocabulary counter.
// Request channel (req_valid/req_stall): one byte of a word per request, with
// req_type and last_byte. A byte that is not the last is taken without a stall.
// On the last byte the block looks the word up: it reduces the hash to a slot
// (reciprocal multiply, subtract, correct) and reads the slot, then for each
// candidate entry reads and checks the length and compares the word byte by
// byte, then reads the count, updates it and loads the result. A newly
// inserted word is appended and its bytes are copied one at a time instead. A
// slot miss that falls back to the linear scan repeats the candidate step for
// each stored entry in turn until one matches.
// Requests are stalled while a word is being looked up.
// Result channel (res_valid/res_stall): one result per final byte and per
// clear. A stalled result holds; the next result waits for it to drain.
// Reset and a clear request both run a clearing pass over the hash slot
// memory, one slot per cycle, during which requests are stalled. A clear
// request then returns one result.
module hashed_word_vocabulary_counter
  import hwvc_pkg::*;
#(
  parameter int unsigned MAX_WORDS    = 4096,
  parameter int unsigned MAX_WORD_LEN = 64,
  parameter int unsigned HASH_SLOTS   = 65536
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  logic [1:0]              req_type,
  input  logic [7:0]              char_byte,
  input  logic                    last_byte,
  output logic                    res_valid,
  input  logic                    res_stall,
  output logic signed [OUT_W-1:0] word_index,
  output logic                    is_new,
  output logic [CNT_W-1:0]        word_count,
  output logic                    table_full,
  output logic [OUT_W-1:0]        stored_words
);

  cmd_t cmd;
  sts_t sts;

  // Request sequencing.
  hwvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .last_byte (last_byte),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hashing, tables and result register.
  hwvc_dp #(
    .MAX_WORDS    (MAX_WORDS),
    .MAX_WORD_LEN (MAX_WORD_LEN),
    .HASH_SLOTS   (HASH_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (req_type),
    .char_byte    (char_byte),
    .last_byte    (last_byte),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .word_index   (word_index),
    .is_new       (is_new),
    .word_count   (word_count),
    .table_full   (table_full),
    .stored_words (stored_words)
  );

endmodule

// ----- rtl/core/hwvc_dp.sv -----
module hwvc_dp
  import hwvc_pkg::*;
#(
  parameter int unsigned MAX_WORDS    = 4096,
  parameter int unsigned MAX_WORD_LEN = 64,
  parameter int unsigned HASH_SLOTS   = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [1:0]        req_type,
  input  logic [7:0]        char_byte,
  input  logic              last_byte,
  output logic              res_valid,
  input  logic              res_stall,
  output logic signed [OUT_W-1:0] word_index,
  output logic              is_new,
  output logic [CNT_W-1:0]  word_count,
  output logic              table_full,
  output logic [OUT_W-1:0]  stored_words
);

  localparam int unsigned SW = $clog2(HASH_SLOTS);
  localparam int unsigned EW = $clog2(MAX_WORDS);
  localparam int unsigned VW = $clog2(MAX_WORDS + 1);
  localparam int unsigned KW = $clog2(MAX_WORD_LEN);
  localparam int unsigned LW = $clog2(MAX_WORD_LEN + 1);
  localparam logic [31:0]   MOD_V     = 32'(HASH_SLOTS);
  localparam logic [63:0]   RECIP_N   = 64'd1 << (31 + SW);
  localparam logic [31:0]   RECIP     = 32'(RECIP_N / 64'(HASH_SLOTS));
  localparam logic [SW-1:0] SENT_SLOT = SW'(SENT_HASH % HASH_SLOTS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(HASH_SLOTS - 1);
  localparam logic [VW-1:0] VMAX      = VW'(MAX_WORDS);
  localparam logic [LW-1:0] LMAX      = LW'(MAX_WORD_LEN);

  // Memories.
  logic [EW:0]        slot_mem [HASH_SLOTS];
  logic [LW-1:0]      len_mem  [MAX_WORDS];
  logic [CNT_W-1:0]   cnt_mem  [MAX_WORDS];
  logic [7:0]         wstore   [MAX_WORDS][MAX_WORD_LEN];
  logic [7:0]         pending  [MAX_WORD_LEN];

  // Registers.
  logic [31:0]      h;
  logic [LW-1:0]    plen;
  logic             req_cnt;
  logic [63:0]      prod;
  logic [31:0]      qm;
  logic [31:0]      rem;
  logic [1:0]       bcnt;
  logic [SW-1:0]    sweep;
  logic [EW-1:0]    cand;
  logic             scan;
  logic [VW-1:0]    vocab;
  logic [KW-1:0]    k;
  logic [EW:0]      slot_q;
  logic [LW-1:0]    len_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_res;
  logic [7:0]       ws_q;
  logic [7:0]       pw_q;

  logic [31:0]      quo;
  logic [SW-1:0]    slot;
  logic [EW-1:0]    vocab_e;
  logic [CNT_W-1:0] cnt_inc;
  logic [VW-1:0]    vocab_n;

  assign quo     = 32'(prod >> (31 + SW));
  assign slot    = rem[SW-1:0];
  assign vocab_e = vocab[EW-1:0];
  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + CNT_W'(1);
  assign vocab_n = vocab + VW'(1);

  // Status toward the controller.
  always_comb begin
    sts.clr_last   = (sweep == LAST_SLOT);
    sts.mod_last   = (bcnt == 2'd2);
    sts.slot_valid = slot_q[EW];
    sts.slot_hit   = slot_q[EW] && (VW'(slot_q[EW-1:0]) < vocab);
    sts.len_eq     = (len_q == plen);
    sts.len_zero   = (plen == '0);
    sts.byte_eq    = (ws_q == pw_q);
    sts.k_last     = (LW'(k) == plen - LW'(1));
    sts.scan       = scan;
    sts.scan_end   = (VW'(cand) == vocab - VW'(1));
    sts.req_cnt    = req_cnt;
    sts.full_now   = (vocab == VMAX);
    sts.out_free   = !res_valid || !res_stall;
  end

  // Control registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      plen      <= '0;
      h         <= '0;
      vocab     <= VW'(1);
    end else begin
      if (cmd.resp_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (cmd.clr_init || cmd.resp_load) begin
        plen <= '0;
        h    <= '0;
      end else if (cmd.take && plen < LMAX) begin
        plen <= plen + LW'(1);
        h    <= h * HASH_MUL + {{24{char_byte[7]}}, char_byte};
      end
      if (cmd.clr_init) begin
        vocab <= VW'(1);
      end else if (cmd.resp_load && cmd.kind == RK_NEW) begin
        vocab <= vocab_n;
      end
    end
  end

  // Working registers of the lookup.
  always_ff @(posedge clk) begin
    if (cmd.take && last_byte) begin
      req_cnt <= (req_type == REQ_COUNT);
    end
    if (cmd.clr_init) begin
      sweep <= '0;
    end else if (cmd.clr_step) begin
      sweep <= sweep + SW'(1);
    end
    // Slot index: the quotient comes from a reciprocal multiply and is at
    // most one short, so one conditional subtraction finishes the remainder.
    if (cmd.mod_init) begin
      prod <= {32'd0, h} * {32'd0, RECIP};
      bcnt <= '0;
    end else if (cmd.mod_step) begin
      bcnt <= bcnt + 2'd1;
      if (bcnt == 2'd0) begin
        qm <= quo * MOD_V;
      end else if (bcnt == 2'd1) begin
        rem <= h - qm;
      end else begin
        rem <= (rem >= MOD_V) ? rem - MOD_V : rem;
      end
    end
    if (cmd.from_slot) begin
      cand <= slot_q[EW-1:0];
      scan <= 1'b0;
    end else if (cmd.scan_init) begin
      cand <= '0;
      scan <= 1'b1;
    end else if (cmd.cand_next) begin
      cand <= cand + EW'(1);
    end
    if (cmd.cmp_init || cmd.append) begin
      k <= '0;
    end else if (cmd.k_next) begin
      k <= k + KW'(1);
    end
    if (cmd.cnt_upd) begin
      cnt_res <= req_cnt ? cnt_inc : cnt_q;
    end
  end

  // Slot memory: clearing pass, repoint after scan, insert.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      slot_mem[sweep] <= {sweep == SENT_SLOT, {EW{1'b0}}};
    end else if (cmd.slot_wr) begin
      slot_mem[slot] <= {1'b1, cand};
    end else if (cmd.append) begin
      slot_mem[slot] <= {1'b1, vocab_e};
    end
    slot_q <= slot_mem[slot];
  end

  // Entry length memory.
  always_ff @(posedge clk) begin
    if (cmd.clr_step && sweep == '0) begin
      len_mem[0] <= LW'(SENT_LEN);
    end else if (cmd.append) begin
      len_mem[vocab_e] <= plen;
    end
    len_q <= len_mem[cand];
  end

  // Entry count memory.
  always_ff @(posedge clk) begin
    if (cmd.clr_step && sweep == '0) begin
      cnt_mem[0] <= '0;
    end else if (cmd.append) begin
      cnt_mem[vocab_e] <= CNT_W'(1);
    end else if (cmd.cnt_upd && req_cnt) begin
      cnt_mem[cand] <= cnt_inc;
    end
    cnt_q <= cnt_mem[cand];
  end

  // Word byte store.
  always_ff @(posedge clk) begin
    if (cmd.clr_step && sweep < SW'(SENT_LEN)) begin
      wstore[0][KW'(sweep[1:0])] <= endw_byte(sweep[1:0]);
    end else if (cmd.copy_wr) begin
      wstore[vocab_e][k] <= pw_q;
    end
    ws_q <= wstore[cand][k];
  end

  // Bytes of the word being received.
  always_ff @(posedge clk) begin
    if (cmd.take && plen < LMAX) begin
      pending[plen[KW-1:0]] <= char_byte;
    end
    pw_q <= pending[k];
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      unique case (cmd.kind)
        RK_CLEAR: begin
          word_index   <= '1;
          is_new       <= 1'b0;
          word_count   <= '0;
          table_full   <= 1'b0;
          stored_words <= OUT_W'(1);
        end
        RK_ABSENT: begin
          word_index   <= '1;
          is_new       <= 1'b0;
          word_count   <= '0;
          table_full   <= req_cnt;
          stored_words <= OUT_W'(vocab);
        end
        RK_FOUND: begin
          word_index   <= OUT_W'(cand);
          is_new       <= 1'b0;
          word_count   <= cnt_res;
          table_full   <= 1'b0;
          stored_words <= OUT_W'(vocab);
        end
        default: begin
          word_index   <= OUT_W'(vocab_e);
          is_new       <= 1'b1;
          word_count   <= CNT_W'(1);
          table_full   <= 1'b0;
          stored_words <= OUT_W'(vocab_n);
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The vocabulary always holds the sentinel and never overflows.
  a_vocab_range: assert property (@(posedge clk) disable iff (rst)
    vocab != '0 && vocab <= VMAX)
    else $error("vocabulary size out of range");

  // The received word never grows past the longest word kept.
  a_plen_range: assert property (@(posedge clk) disable iff (rst)
    plen <= LMAX)
    else $error("pending length out of range");

  // An insert and its byte copy only happen while the table has room.
  a_append_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.append || cmd.copy_wr) |-> vocab < VMAX)
    else $error("insert into a full table");

  // A found result always names a stored entry.
  a_found_entry: assert property (@(posedge clk) disable iff (rst)
    (cmd.resp_load && cmd.kind == RK_FOUND) |-> VW'(cand) < vocab)
    else $error("found entry beyond vocabulary");
`endif

endmodule

// ----- rtl/core/hwvc_ctrl.sv -----
module hwvc_ctrl
  import hwvc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] req_type,
  input  logic       last_byte,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [16:0] {
    S_CINIT = 17'h00001,
    S_CLR   = 17'h00002,
    S_IDLE  = 17'h00004,
    S_MODI  = 17'h00008,
    S_MOD   = 17'h00010,
    S_SLRD  = 17'h00020,
    S_SLCK  = 17'h00040,
    S_LNRD  = 17'h00080,
    S_LNCK  = 17'h00100,
    S_CMRD  = 17'h00200,
    S_CMCK  = 17'h00400,
    S_CNRD  = 17'h00800,
    S_CNCK  = 17'h01000,
    S_APND  = 17'h02000,
    S_CPRD  = 17'h04000,
    S_CPWR  = 17'h08000,
    S_RESP  = 17'h10000
  } state_t;

  state_t     state, state_next;
  logic       pend_clr, pend_clr_next;
  resp_kind_t kind, kind_next;
  logic       accept;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CINIT;
      pend_clr <= 1'b0;
      kind     <= RK_CLEAR;
    end else begin
      state    <= state_next;
      pend_clr <= pend_clr_next;
      kind     <= kind_next;
    end
  end

  // Sequencing of one request.
  always_comb begin
    state_next    = state;
    pend_clr_next = pend_clr;
    kind_next     = kind;
    cmd           = '0;
    cmd.kind      = kind;
    unique case (state)
      S_CINIT: begin
        cmd.clr_init = 1'b1;
        state_next   = S_CLR;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          kind_next  = RK_CLEAR;
          state_next = pend_clr ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (req_type == REQ_CLEAR) begin
            pend_clr_next = 1'b1;
            state_next    = S_CINIT;
          end else begin
            cmd.take = 1'b1;
            if (last_byte) begin
              state_next = S_MODI;
            end
          end
        end
      end
      S_MODI: begin
        cmd.mod_init = 1'b1;
        state_next   = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_next = S_SLRD;
        end
      end
      S_SLRD: begin
        state_next = S_SLCK;
      end
      S_SLCK: begin
        if (sts.slot_hit) begin
          cmd.from_slot = 1'b1;
          state_next    = S_LNRD;
        end else if (sts.slot_valid) begin
          cmd.scan_init = 1'b1;
          state_next    = S_LNRD;
        end else if (sts.req_cnt && !sts.full_now) begin
          state_next = S_APND;
        end else begin
          kind_next  = RK_ABSENT;
          state_next = S_RESP;
        end
      end
      S_LNRD: begin
        state_next = S_LNCK;
      end
      S_LNCK, S_CMCK: begin
        if ((state == S_LNCK && sts.len_eq && sts.len_zero) ||
            (state == S_CMCK && sts.byte_eq && sts.k_last)) begin
          // Match: repoint the slot when the scan found it.
          cmd.slot_wr = sts.scan;
          state_next  = S_CNRD;
        end else if (state == S_LNCK && sts.len_eq) begin
          cmd.cmp_init = 1'b1;
          state_next   = S_CMRD;
        end else if (state == S_CMCK && sts.byte_eq) begin
          cmd.k_next = 1'b1;
          state_next = S_CMRD;
        end else if (!sts.scan) begin
          cmd.scan_init = 1'b1;
          state_next    = S_LNRD;
        end else if (!sts.scan_end) begin
          cmd.cand_next = 1'b1;
          state_next    = S_LNRD;
        end else if (sts.req_cnt && !sts.full_now) begin
          state_next = S_APND;
        end else begin
          kind_next  = RK_ABSENT;
          state_next = S_RESP;
        end
      end
      S_CMRD: begin
        state_next = S_CMCK;
      end
      S_CNRD: begin
        state_next = S_CNCK;
      end
      S_CNCK: begin
        cmd.cnt_upd = 1'b1;
        kind_next   = RK_FOUND;
        state_next  = S_RESP;
      end
      S_APND: begin
        cmd.append = 1'b1;
        kind_next  = RK_NEW;
        state_next = sts.len_zero ? S_RESP : S_CPRD;
      end
      S_CPRD: begin
        state_next = S_CPWR;
      end
      S_CPWR: begin
        cmd.copy_wr = 1'b1;
        if (sts.k_last) begin
          state_next = S_RESP;
        end else begin
          cmd.k_next = 1'b1;
          state_next = S_CPRD;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.resp_load = 1'b1;
          pend_clr_next = 1'b0;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_CINIT;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Requests are only taken while idle.
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> state == S_IDLE)
    else $error("byte taken outside idle");

  // A result is loaded only when the output register can take it.
  a_resp_free: assert property (@(posedge clk) disable iff (rst)
    cmd.resp_load |-> sts.out_free)
    else $error("result overwritten");

  // A clear request ends in a clear result.
  a_clear_kind: assert property (@(posedge clk) disable iff (rst)
    (cmd.resp_load && pend_clr) |-> cmd.kind == RK_CLEAR)
    else $error("clear gave wrong result kind");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import hwvc_pkg::*;

  // Type 3 has no name in the package; the block treats it as a lookup.
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int unsigned N_WORDS = 4096;
  localparam int unsigned N_LEN   = 64;
  localparam int unsigned N_SLOTS = 65536;

  typedef struct packed {
    logic signed [OUT_W-1:0] idx;
    logic                    nw;
    logic [CNT_W-1:0]        cnt;
    logic                    full;
    logic [OUT_W-1:0]        vsz;
  } vocab_res_t;

  logic clk;
  logic rst;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [1:0] req_type = REQ_COUNT;
  logic [7:0] char_byte = 8'h00;
  logic last_byte = 1'b0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic signed [OUT_W-1:0] word_index;
  logic is_new;
  logic [CNT_W-1:0] word_count;
  logic table_full;
  logic [OUT_W-1:0] stored_words;

  hashed_word_vocabulary_counter DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .req_type(req_type), .char_byte(char_byte), .last_byte(last_byte),
    .res_valid(res_valid), .res_stall(res_stall),
    .word_index(word_index), .is_new(is_new), .word_count(word_count),
    .table_full(table_full), .stored_words(stored_words)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predicted vocabulary state.
  int unsigned slot_entry [N_SLOTS];
  bit          slot_used  [N_SLOTS];
  logic [7:0]  entry_bytes [N_WORDS][N_LEN];
  int unsigned entry_len   [N_WORDS];
  logic [31:0] entry_count [N_WORDS];
  int unsigned n_entries;
  logic [7:0]  word_buf [N_LEN];
  int unsigned word_len;
  logic [31:0] word_hash;

  vocab_res_t expected_q [$];
  int send_idle_pct;
  int stall_pct;
  int mismatches;
  int results_seen;
  int bytes_sent;
  int words_sent;
  int clears_sent;

  function automatic logic [31:0] mix_byte(logic [31:0] h, logic [7:0] b);
    return h * 32'd237 + {{24{b[7]}}, b};
  endfunction

  function automatic void table_init();
    logic [31:0] h;
    h = 32'd0;
    for (int s = 0; s < N_SLOTS; s++) begin
      slot_used[s] = 1'b0;
      slot_entry[s] = 0;
    end
    for (int e = 0; e < N_WORDS; e++) begin
      entry_len[e] = 0;
      entry_count[e] = 32'd0;
    end
    entry_bytes[0][0] = "<";
    entry_bytes[0][1] = "/";
    entry_bytes[0][2] = "s";
    entry_bytes[0][3] = ">";
    for (int i = 0; i < 4; i++) h = mix_byte(h, entry_bytes[0][i]);
    slot_used[h % N_SLOTS] = 1'b1;
    slot_entry[h % N_SLOTS] = 0;
    entry_len[0] = 4;
    n_entries = 1;
    word_len = 0;
    word_hash = 32'd0;
  endfunction

  function automatic bit matches_entry(int unsigned e);
    if (e >= N_WORDS || entry_len[e] != word_len) return 1'b0;
    for (int i = 0; i < word_len; i++)
      if (entry_bytes[e][i] != word_buf[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Applies one accepted request; returns 1 when it produces a result.
  function automatic bit vocab_update(logic [1:0] rt, logic [7:0] b, bit lb,
                                      output vocab_res_t r);
    int idx;
    int unsigned slot;
    int unsigned e;
    r = '0;
    idx = -1;
    if (rt == REQ_CLEAR) begin
      table_init();
      r.idx = '1;
      r.vsz = OUT_W'(n_entries);
      return 1'b1;
    end
    if (word_len < N_LEN) begin
      word_buf[word_len] = b;
      word_len++;
      word_hash = mix_byte(word_hash, b);
    end
    if (!lb) return 1'b0;
    slot = word_hash % N_SLOTS;
    // The slot's candidate first, then a scan over all entries.
    if (slot_used[slot]) begin
      e = slot_entry[slot];
      if (e < n_entries && matches_entry(e)) begin
        idx = e;
      end else begin
        for (e = 0; e < n_entries; e++) begin
          if (matches_entry(e)) begin
            slot_entry[slot] = e;
            idx = e;
            break;
          end
        end
      end
    end
    if (rt == REQ_COUNT) begin
      if (idx >= 0) begin
        if (entry_count[idx] != 32'hFFFF_FFFF) entry_count[idx]++;
        r.cnt = entry_count[idx];
      end else if (n_entries >= N_WORDS) begin
        r.full = 1'b1;
      end else begin
        idx = n_entries;
        for (int i = 0; i < word_len; i++) entry_bytes[idx][i] = word_buf[i];
        entry_len[idx] = word_len;
        entry_count[idx] = 32'd1;
        n_entries++;
        slot_entry[slot] = idx;
        slot_used[slot] = 1'b1;
        r.nw = 1'b1;
        r.cnt = 32'd1;
      end
    end else if (idx >= 0) begin
      r.cnt = entry_count[idx];
    end
    word_len = 0;
    word_hash = 32'd0;
    r.idx = OUT_W'(idx);
    r.vsz = OUT_W'(n_entries);
    return 1'b1;
  endfunction

  function automatic int unsigned slot_of(logic [7:0] w [$]);
    logic [31:0] h;
    h = 32'd0;
    foreach (w[i]) h = mix_byte(h, w[i]);
    return h % N_SLOTS;
  endfunction

  // Sends one request byte, with random idle cycles before it.
  task automatic send_req(logic [1:0] rt, logic [7:0] b, bit lb);
    vocab_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type <= rt;
    char_byte <= b;
    last_byte <= lb;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (vocab_update(rt, b, lb, r)) expected_q.push_back(r);
    bytes_sent++;
  endtask

  // Sends a word; the earlier bytes carry arbitrary non-clear types.
  task automatic send_word(logic [7:0] w [$], logic [1:0] rt);
    logic [1:0] mid;
    for (int i = 0; i < w.size(); i++) begin
      mid = 2'($urandom_range(2));
      if (mid == REQ_CLEAR) mid = REQ_SPARE;
      send_req((i == w.size() - 1) ? rt : mid, w[i], i == w.size() - 1);
    end
    words_sent++;
  endtask

  task automatic send_clear();
    send_req(REQ_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
    clears_sent++;
  endtask

  // Holds the request side until every expected result has arrived.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 59; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 59; end
      default: begin send_idle_pct = 11; stall_pct = 11; end
    endcase
  endtask

  // Result checker against the oldest expectation.
  always @(posedge clk) begin
    vocab_res_t exp_r;
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: index %0d count %0d", word_index, word_count);
      end else begin
        exp_r = expected_q.pop_front();
        if (word_index !== exp_r.idx || is_new !== exp_r.nw ||
            word_count !== exp_r.cnt || table_full !== exp_r.full ||
            stored_words !== exp_r.vsz) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp idx %0d new %0b cnt %0d full %0b size %0d,",
                      " got %0d %0b %0d %0b %0d"},
                     exp_r.idx, exp_r.nw, exp_r.cnt, exp_r.full, exp_r.vsz,
                     word_index, is_new, word_count, table_full, stored_words);
        end
      end
    end
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // Extremes, every request type, overlong words and clearing mid-word.
  task automatic test_directed();
    logic [7:0] w [$];
    set_idling(3);
    w = '{8'h3C, 8'h2F, 8'h73, 8'h3E};
    send_word(w, REQ_LOOKUP);
    send_word(w, REQ_COUNT);
    send_word('{8'h00}, REQ_COUNT);
    send_word('{8'hFF}, REQ_COUNT);
    send_word('{8'h80}, REQ_SPARE);
    send_word('{8'h80}, REQ_COUNT);
    send_word('{8'h7F, 8'h00}, REQ_LOOKUP);
    send_word('{8'h00}, REQ_COUNT);
    send_word('{8'hFF}, REQ_SPARE);
    // Only the first 64 bytes count, so both words end in the same entry.
    w = {};
    for (int i = 0; i < 70; i++) w.push_back(8'($urandom_range(255)));
    send_word(w, REQ_COUNT);
    w[68] = ~w[68];
    send_word(w, REQ_COUNT);
    // A clear drops the partial word.
    send_req(REQ_COUNT, 8'h41, 1'b0);
    send_req(REQ_LOOKUP, 8'h42, 1'b0);
    send_clear();
    send_word('{8'h42}, REQ_COUNT);
    drain();
  endtask

  // Two words sharing a slot force the scan and the slot repointing.
  task automatic test_collision();
    logic [7:0] w [$];
    logic [7:0] a [$];
    logic [23:0] owner [int unsigned];
    int unsigned s;
    set_idling(2);
    forever begin
      w = '{8'($urandom_range(255)), 8'($urandom_range(255)),
            8'($urandom_range(255))};
      s = slot_of(w);
      if (!slot_used[s]) begin
        if (owner.exists(s) && owner[s] != {w[0], w[1], w[2]}) break;
        owner[s] = {w[0], w[1], w[2]};
      end
    end
    a = '{owner[s][23:16], owner[s][15:8], owner[s][7:0]};
    send_word(a, REQ_COUNT);
    send_word(w, REQ_LOOKUP);
    send_word(w, REQ_COUNT);
    send_word(a, REQ_COUNT);
    send_word(w, REQ_SPARE);
    send_word(a, REQ_LOOKUP);
    drain();
  endtask

  // Random words over a small alphabet so that repeats are common.
  task automatic test_random(int mode, int n_bytes);
    logic [7:0] w [$];
    int len;
    int pick;
    int stop_at;
    set_idling(mode);
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      len = (pick < 5) ? $urandom_range(70, 60) : $urandom_range(4, 1);
      w = {};
      for (int i = 0; i < len; i++)
        w.push_back(($urandom_range(9) < 7) ? 8'(8'h61 + $urandom_range(3))
                                             : 8'($urandom_range(255)));
      pick = $urandom_range(99);
      send_word(w, (pick < 60) ? REQ_COUNT : (pick < 85) ? REQ_LOOKUP : REQ_SPARE);
    end
    drain();
  endtask

  initial begin
    mismatches = 0;
    results_seen = 0;
    bytes_sent = 0;
    words_sent = 0;
    clears_sent = 0;
    set_idling(0);
    table_init();
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_collision();
    test_random(0, 280);
    test_random(1, 280);
    test_random(2, 280);
    test_random(3, 280);
    req_valid <= 1'b0;
    repeat (200) @(posedge clk);
    $display("Covered %0d bytes in %0d words and %0d clears, %0d results checked,",
             bytes_sent, words_sent, clears_sent, results_seen);
    $display("including slot collisions, overlong words and a clear inside a word.");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
